// ===== sv/range_distinct_count_assert.svh =====
// range_distinct_count_assert.svh: assertion macros for the distinct count block
// no dependencies; included by the top level
`ifndef RANGE_DISTINCT_COUNT_ASSERT_SVH
`define RANGE_DISTINCT_COUNT_ASSERT_SVH
`ifndef NO_ASSERTIONS
// same-cycle implication
`define RDC_ASSERT_IMPL(name, clk, rst, ante, cons) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("range_distinct_count: same-cycle check failed");
// next-cycle implication
`define RDC_ASSERT_NEXT(name, clk, rst, ante, cons) \
   name: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("range_distinct_count: next-cycle check failed");
`else
`define RDC_ASSERT_IMPL(name, clk, rst, ante, cons)
`define RDC_ASSERT_NEXT(name, clk, rst, ante, cons)
`endif
`endif

// ===== sv/rdc_pkg.sv =====
// rdc_pkg: payload, command and status types shared by the distinct count block
// no dependencies
package rdc_pkg;

   localparam int FIELD_WIDTH = 10;
   localparam int COUNT_WIDTH = 11;

   localparam logic KIND_LOAD  = 1'b0;
   localparam logic KIND_QUERY = 1'b1;

   // request payload
   typedef struct packed {
      logic                   kind;
      logic [FIELD_WIDTH-1:0] position;
      logic [FIELD_WIDTH-1:0] element_value;
      logic [FIELD_WIDTH-1:0] left;
      logic [FIELD_WIDTH-1:0] right;
   } req_type;

   // response payload
   typedef struct packed {
      logic [COUNT_WIDTH-1:0] distinct_count;
      logic                   range_error;
   } rsp_type;

   // controller states
   typedef enum logic [3:0] {
      ST_CLEAR,
      ST_IDLE,
      ST_DECIDE,
      ST_GROW_CRD,
      ST_GROW_CWR,
      ST_SHRINK_CRD,
      ST_SHRINK_CWR,
      ST_LOAD_CRD,
      ST_LOAD_DOWN_WR,
      ST_LOAD_UP_RD,
      ST_LOAD_UP_WR,
      ST_RESPOND
   } state_type;

   // element store read address and window pointer move
   typedef enum logic [2:0] {
      ELEM_GROW_END,
      ELEM_GROW_LOW,
      ELEM_SHRINK_END,
      ELEM_SHRINK_LOW,
      ELEM_LOAD_POS
   } elem_sel_type;

   // count store read address source
   typedef enum logic {
      CNT_SRC_ELEM,
      CNT_SRC_REQ
   } cnt_src_type;

   // controller to datapath
   typedef struct packed {
      logic         capture;
      logic         clear_step;
      logic         elem_rd;
      elem_sel_type elem_sel;
      logic         elem_wr;
      logic         cnt_rd;
      cnt_src_type  cnt_src;
      logic         cnt_wr;
      logic         cnt_up;
      logic         rsp_push;
   } cmd_type;

   // datapath to controller
   typedef struct packed {
      logic kind_query;
      logic query_bad;
      logic load_ok;
      logic in_window;
      logic grow_end;
      logic grow_low;
      logic shrink_end;
      logic shrink_low;
      logic clear_last;
   } status_type;

endpackage

// ===== sv/rdc_datapath.sv =====
// rdc_datapath: element store, count store, window pointers and distinct total
// depends on rdc_pkg
module rdc_datapath import rdc_pkg::*; #(
   parameter int ARRAY_DEPTH = 1024,
   parameter int VALUE_RANGE = 1024
) (
   input  logic       clock,
   input  logic       reset,
   input  req_type    req_data,
   input  cmd_type    cmd,
   output status_type status,
   output rsp_type    rsp_result
);

   localparam int AW = $clog2(ARRAY_DEPTH);
   localparam int PW = AW + 1;
   localparam int VW = $clog2(VALUE_RANGE);

   // memories
   logic [VW-1:0]          elem_mem [ARRAY_DEPTH];
   logic [COUNT_WIDTH-1:0] cnt_mem  [VALUE_RANGE];

   // registers
   req_type                req_ff;
   logic [AW-1:0]          low_ff, low_in;
   logic [PW-1:0]          end_ff, end_in;
   logic [COUNT_WIDTH-1:0] total_ff, total_in;
   logic [VW-1:0]          clr_ff, clr_in;
   logic [VW-1:0]          cnt_addr_ff;
   logic [VW-1:0]          elem_q_ff;
   logic [COUNT_WIDTH-1:0] cnt_q_ff;

   // combinational
   logic [31:0]            pos_ext, val_ext, lo_ext, hi_ext;
   logic [PW-1:0]          pos_w, lo_tgt, end_tgt, low_w, end_dec;
   logic                   query_bad;
   logic [AW-1:0]          elem_addr;
   logic [VW-1:0]          cnt_rd_addr;
   logic [COUNT_WIDTH-1:0] cnt_inc, cnt_dec;
   logic                   cnt_we;
   logic [VW-1:0]          cnt_waddr;
   logic [COUNT_WIDTH-1:0] cnt_wdata;

   // request fields widened for range checks
   assign pos_ext = 32'(req_ff.position);
   assign val_ext = 32'(req_ff.element_value);
   assign lo_ext  = 32'(req_ff.left);
   assign hi_ext  = 32'(req_ff.right);

   assign pos_w   = pos_ext[PW-1:0];
   assign lo_tgt  = lo_ext[PW-1:0];
   assign end_tgt = PW'(hi_ext + 32'd1);
   assign low_w   = {1'b0, low_ff};
   assign end_dec = end_ff - 1'b1;

   assign query_bad = (lo_ext > hi_ext) || (hi_ext >= 32'(ARRAY_DEPTH));

   // status towards the controller
   always_comb begin
      status.kind_query = (req_ff.kind == KIND_QUERY);
      status.query_bad  = query_bad;
      status.load_ok    = (pos_ext < 32'(ARRAY_DEPTH)) && (val_ext < 32'(VALUE_RANGE));
      status.in_window  = (pos_w >= low_w) && (pos_w < end_ff);
      status.grow_end   = end_ff < end_tgt;
      status.grow_low   = low_w > lo_tgt;
      status.shrink_end = end_ff > end_tgt;
      status.shrink_low = low_w < lo_tgt;
      status.clear_last = (clr_ff == VW'(VALUE_RANGE - 1));
   end

   // response for the current query
   always_comb begin
      rsp_result.range_error    = query_bad;
      rsp_result.distinct_count = query_bad ? '0 : total_ff;
   end

   // element read address and window edge moves
   always_comb begin
      low_in = low_ff;
      end_in = end_ff;
      case (cmd.elem_sel)
         ELEM_GROW_END:   elem_addr = end_ff[AW-1:0];
         ELEM_GROW_LOW:   elem_addr = low_ff - 1'b1;
         ELEM_SHRINK_END: elem_addr = end_dec[AW-1:0];
         ELEM_SHRINK_LOW: elem_addr = low_ff;
         ELEM_LOAD_POS:   elem_addr = pos_w[AW-1:0];
         default:         elem_addr = low_ff;
      endcase
      if (cmd.elem_rd) begin
         case (cmd.elem_sel)
            ELEM_GROW_END:   end_in = end_ff + 1'b1;
            ELEM_GROW_LOW:   low_in = low_ff - 1'b1;
            ELEM_SHRINK_END: end_in = end_dec;
            ELEM_SHRINK_LOW: low_in = low_ff + 1'b1;
            default: begin
               low_in = low_ff;
               end_in = end_ff;
            end
         endcase
      end
   end

   // count read-modify-write and distinct total
   assign cnt_rd_addr = (cmd.cnt_src == CNT_SRC_REQ) ? val_ext[VW-1:0] : elem_q_ff;
   assign cnt_inc     = cnt_q_ff + 1'b1;
   assign cnt_dec     = cnt_q_ff - 1'b1;

   always_comb begin
      cnt_we    = 1'b0;
      cnt_waddr = cnt_addr_ff;
      cnt_wdata = cnt_inc;
      total_in  = total_ff;
      clr_in    = clr_ff;
      if (cmd.clear_step) begin
         cnt_we    = 1'b1;
         cnt_waddr = clr_ff;
         cnt_wdata = '0;
         clr_in    = clr_ff + 1'b1;
      end else if (cmd.cnt_wr) begin
         if (cmd.cnt_up) begin
            cnt_we    = 1'b1;
            cnt_wdata = cnt_inc;
            if (cnt_inc == COUNT_WIDTH'(1)) begin
               total_in = total_ff + 1'b1;
            end
         end else if (cnt_q_ff != '0) begin
            cnt_we    = 1'b1;
            cnt_wdata = cnt_dec;
            if (cnt_dec == '0) begin
               total_in = total_ff - 1'b1;
            end
         end
      end
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         low_ff   <= '0;
         end_ff   <= '0;
         total_ff <= '0;
         clr_ff   <= '0;
      end else begin
         low_ff   <= low_in;
         end_ff   <= end_in;
         total_ff <= total_in;
         clr_ff   <= clr_in;
      end
   end

   // request hold and count address
   always_ff @(posedge clock) begin
      if (cmd.capture) begin
         req_ff <= req_data;
      end
      if (cmd.cnt_rd) begin
         cnt_addr_ff <= cnt_rd_addr;
      end
   end

   // element store, registered read
   always_ff @(posedge clock) begin
      if (cmd.elem_wr) begin
         elem_mem[pos_w[AW-1:0]] <= val_ext[VW-1:0];
      end
      if (cmd.elem_rd) begin
         elem_q_ff <= elem_mem[elem_addr];
      end
   end

   // count store, registered read
   always_ff @(posedge clock) begin
      if (cnt_we) begin
         cnt_mem[cnt_waddr] <= cnt_wdata;
      end
      if (cmd.cnt_rd) begin
         cnt_q_ff <= cnt_mem[cnt_rd_addr];
      end
   end

endmodule

// ===== sv/rdc_ctrl.sv =====
// rdc_ctrl: sequencer for clearing, loads and window walks of the distinct count block
// depends on rdc_pkg
module rdc_ctrl import rdc_pkg::*; (
   input  logic       clock,
   input  logic       reset,
   input  logic       req_valid,
   input  status_type status,
   input  logic       rsp_free,
   output logic       req_ready,
   output cmd_type    cmd
);

   state_type state_ff, state_in;

   // state register
   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR;
      end else begin
         state_ff <= state_in;
      end
   end

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         ST_CLEAR: begin
            if (status.clear_last) state_in = ST_IDLE;
         end
         ST_IDLE: begin
            if (req_valid) state_in = ST_DECIDE;
         end
         ST_DECIDE: begin
            if (status.kind_query) begin
               if (status.query_bad) begin
                  state_in = ST_RESPOND;
               end else if (status.grow_end || status.grow_low) begin
                  state_in = ST_GROW_CRD;
               end else if (status.shrink_end || status.shrink_low) begin
                  state_in = ST_SHRINK_CRD;
               end else begin
                  state_in = ST_RESPOND;
               end
            end else if (status.load_ok && status.in_window) begin
               state_in = ST_LOAD_CRD;
            end else begin
               state_in = ST_IDLE;
            end
         end
         ST_GROW_CRD:     state_in = ST_GROW_CWR;
         ST_GROW_CWR:     state_in = ST_DECIDE;
         ST_SHRINK_CRD:   state_in = ST_SHRINK_CWR;
         ST_SHRINK_CWR:   state_in = ST_DECIDE;
         ST_LOAD_CRD:     state_in = ST_LOAD_DOWN_WR;
         ST_LOAD_DOWN_WR: state_in = ST_LOAD_UP_RD;
         ST_LOAD_UP_RD:   state_in = ST_LOAD_UP_WR;
         ST_LOAD_UP_WR:   state_in = ST_IDLE;
         ST_RESPOND: begin
            if (rsp_free) state_in = ST_IDLE;
         end
         default:         state_in = ST_CLEAR;
      endcase
   end

   // commands
   always_comb begin
      cmd          = '0;
      cmd.elem_sel = ELEM_GROW_END;
      cmd.cnt_src  = CNT_SRC_ELEM;
      req_ready    = 1'b0;
      case (state_ff)
         ST_CLEAR: begin
            cmd.clear_step = 1'b1;
         end
         ST_IDLE: begin
            req_ready   = 1'b1;
            cmd.capture = req_valid;
         end
         ST_DECIDE: begin
            // grow first, then shrink, so no count drops below zero
            if (status.kind_query) begin
               if (!status.query_bad) begin
                  if (status.grow_end) begin
                     cmd.elem_rd  = 1'b1;
                     cmd.elem_sel = ELEM_GROW_END;
                  end else if (status.grow_low) begin
                     cmd.elem_rd  = 1'b1;
                     cmd.elem_sel = ELEM_GROW_LOW;
                  end else if (status.shrink_end) begin
                     cmd.elem_rd  = 1'b1;
                     cmd.elem_sel = ELEM_SHRINK_END;
                  end else if (status.shrink_low) begin
                     cmd.elem_rd  = 1'b1;
                     cmd.elem_sel = ELEM_SHRINK_LOW;
                  end
               end
            end else if (status.load_ok) begin
               if (status.in_window) begin
                  cmd.elem_rd  = 1'b1;
                  cmd.elem_sel = ELEM_LOAD_POS;
               end else begin
                  cmd.elem_wr = 1'b1;
               end
            end
         end
         ST_GROW_CRD, ST_SHRINK_CRD, ST_LOAD_CRD: begin
            cmd.cnt_rd  = 1'b1;
            cmd.cnt_src = CNT_SRC_ELEM;
         end
         ST_GROW_CWR: begin
            cmd.cnt_wr = 1'b1;
            cmd.cnt_up = 1'b1;
         end
         ST_SHRINK_CWR, ST_LOAD_DOWN_WR: begin
            cmd.cnt_wr = 1'b1;
            cmd.cnt_up = 1'b0;
         end
         ST_LOAD_UP_RD: begin
            cmd.cnt_rd  = 1'b1;
            cmd.cnt_src = CNT_SRC_REQ;
         end
         ST_LOAD_UP_WR: begin
            cmd.cnt_wr  = 1'b1;
            cmd.cnt_up  = 1'b1;
            cmd.elem_wr = 1'b1;
         end
         ST_RESPOND: begin
            cmd.rsp_push = rsp_free;
         end
         default: begin
            cmd.clear_step = 1'b0;
         end
      endcase
   end

endmodule

// ===== sv/rdc_rsp_reg.sv =====
// rdc_rsp_reg: response output register between the sequencer and the receiver
// depends on rdc_pkg
module rdc_rsp_reg import rdc_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    push,
   input  rsp_type push_data,
   input  logic    rsp_ready,
   output logic    rsp_valid,
   output rsp_type rsp_data,
   output logic    free
);

   logic    valid_ff, valid_in;
   rsp_type data_ff;

   // slot can take a response when empty or being drained
   assign free      = !valid_ff || rsp_ready;
   assign rsp_valid = valid_ff;
   assign rsp_data  = data_ff;

   always_comb begin
      valid_in = valid_ff;
      if (push) begin
         valid_in = 1'b1;
      end else if (rsp_ready) begin
         valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         valid_ff <= 1'b0;
      end else begin
         valid_ff <= valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         data_ff <= push_data;
      end
   end

endmodule

// ===== sv/range_distinct_count.sv =====
// range_distinct_count: top level of the distinct values in range block
// depends on rdc_pkg, rdc_ctrl, rdc_datapath, rdc_rsp_reg, range_distinct_count_assert.svh
//
// Requests arrive on req_valid/req_ready/req_data. A load request writes one
// element; a query request moves a window [low, end) over the element array to
// [left, right], one element per step, and answers with the number of distinct
// values on rsp_valid/rsp_ready/rsp_data. Loads give no response.
// Each window step is a read of the element store, a read of the count store and
// a count write. A query answers with range_error set and a zero count when
// left > right or right >= ARRAY_DEPTH, without moving the window. A load
// writes the element store; when its position lies inside the current window it
// also lowers the count of the old value and raises that of the new one.
// One request is worked on at a time; the next is taken while a response still
// waits in the output register.
// After reset the count store is cleared, one value per cycle, while req_ready
// stays low. If the receiver stalls, one response is held and the block stops
// before pushing the next one.
`include "range_distinct_count_assert.svh"
module range_distinct_count import rdc_pkg::*; #(
   parameter int ARRAY_DEPTH = 1024,
   parameter int VALUE_RANGE = 1024
) (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_ready,
   input  req_type req_data,
   output logic    rsp_valid,
   input  logic    rsp_ready,
   output rsp_type rsp_data
);

   cmd_type    cmd;
   status_type status;
   rsp_type    rsp_result;
   logic       rsp_free;

   // sequencer
   rdc_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .status    (status),
      .rsp_free  (rsp_free),
      .req_ready (req_ready),
      .cmd       (cmd)
   );

   // stores, window and total
   rdc_datapath #(
      .ARRAY_DEPTH (ARRAY_DEPTH),
      .VALUE_RANGE (VALUE_RANGE)
   ) u_datapath (
      .clock      (clock),
      .reset      (reset),
      .req_data   (req_data),
      .cmd        (cmd),
      .status     (status),
      .rsp_result (rsp_result)
   );

   // response register
   rdc_rsp_reg u_rsp_reg (
      .clock     (clock),
      .reset     (reset),
      .push      (cmd.rsp_push),
      .push_data (rsp_result),
      .rsp_ready (rsp_ready),
      .rsp_valid (rsp_valid),
      .rsp_data  (rsp_data),
      .free      (rsp_free)
   );

   // checks
   `RDC_ASSERT_IMPL(a_no_accept_in_clear, clock, reset, cmd.clear_step, !req_ready)
   `RDC_ASSERT_IMPL(a_push_when_free, clock, reset, cmd.rsp_push, rsp_free)
   `RDC_ASSERT_NEXT(a_single_capture, clock, reset, cmd.capture, !cmd.capture && !req_ready)
   `RDC_ASSERT_IMPL(a_error_zero, clock, reset, rsp_valid && rsp_data.range_error, rsp_data.distinct_count == '0)

endmodule
